// File: rtl/core/pac_pkg.sv
// Shared types and constants for the polygon area and centroid core.
// Holds operand widths, accumulator widths and the sequencer state type.
// No dependencies.
package pac_pkg;

	localparam int COORD_W = 16;                // vertex and centroid coordinates
	localparam int OPA_W   = COORD_W + 1;       // multiplier A: coordinate or coordinate sum
	localparam int OPB_W   = 2 * COORD_W + 1;   // multiplier B: coordinate or cross term
	localparam int PROD_W  = OPA_W + OPB_W;     // full multiplier product
	localparam int AREA_W  = 42;                // doubled signed area accumulator
	localparam int AREA3_W = AREA_W + 2;        // three times the doubled area
	localparam int WSUM_W  = 58;                // weighted coordinate sums
	localparam int DIVR_W  = AREA3_W - 1;       // divisor magnitude
	localparam int QUO_W   = WSUM_W;            // dividend and quotient magnitude
	localparam int DCNT_W  = $clog2(QUO_W);     // divider bit counter

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [OPA_W-1:0]   opa_t;
	typedef logic signed [OPB_W-1:0]   opb_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [AREA_W-1:0]  area_t;
	typedef logic signed [WSUM_W-1:0]  wsum_t;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_X1   = 11'b000_0000_0010,
		S_X2   = 11'b000_0000_0100,
		S_C    = 11'b000_0000_1000,
		S_WX   = 11'b000_0001_0000,
		S_WY   = 11'b000_0010_0000,
		S_ACC  = 11'b000_0100_0000,
		S_DSET = 11'b000_1000_0000,
		S_DIV  = 11'b001_0000_0000,
		S_DFIN = 11'b010_0000_0000,
		S_EMIT = 11'b100_0000_0000
	} state_t;

endpackage

// File: rtl/core/polygon_area_centroid_core.sv
// Polygon area and centroid core by the shoelace formula.
// Depends on pac_pkg for widths, types and the sequencer state encoding.
// Single module: sequencer, one shared multiplier and one shared divider.

// Vertices arrive one item at a time on the input channel as signed 16-bit coordinates, with
// last_vertex marking the final vertex of a polygon. Each vertex after the first is taken in the
// idle state and then works through its edge in S_X1, S_X2, S_C, S_WX, S_WY and S_ACC: four
// products go through the one shared 17 x 33 bit multiplier (two for the cross term, one for each
// weighted sum). A first vertex that is not the last is only stored. The last vertex adds the
// closing edge back to the first vertex, a set-up step, then (for a non-zero doubled area) two
// restoring divisions of 58 quotient bits each on the shared divider, one bit per cycle, each
// followed by a step to saturate, and finally the hand-over of the result to the output
// register. The input is not ready while a vertex or a polygon close is in progress. The result
// sits in an output register, so the next polygon's vertices are taken while it waits; a close
// only stalls in its final hand-over step if the previous result has still not been taken. A
// polygon with zero doubled area gives degenerate set and both coordinates zero. Vertices beyond
// MAX_VERTICES are ignored but raise too_many_vertices on that polygon's result. Centroids are
// truncated toward zero and saturated to the 16-bit signed range.
module polygon_area_centroid_core
	import pac_pkg::*;
#(
	parameter int MAX_VERTICES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// vertex channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   vertex_x,
	input  logic signed [15:0]   vertex_y,
	input  logic                 last_vertex,
	// centroid channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   centroid_x,
	output logic signed [15:0]   centroid_y,
	output logic                 degenerate,
	output logic                 too_many_vertices
);

	// The count must be able to hold MAX_VERTICES itself.
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	state_t state_q;

	// Polygon state.
	coord_t           first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	area_t            area_q;
	wsum_t            wx_q, wy_q;
	logic             last_q;
	logic             closing_q;

	// Operands of the edge in progress.
	coord_t p_x_q, p_y_q, q_x_q, q_y_q;

	// Shared multiplier.
	opa_t  mul_a;
	opb_t  mul_b;
	prod_t mul_q;
	opb_t  c_q;

	// Shared divider.
	logic [DIVR_W-1:0] dmag_q;
	logic              dneg_q;
	logic [QUO_W-1:0]  num_q;
	logic              nneg_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              div_sel_q;

	// Result held until the output register is free.
	coord_t res_x_q, res_y_q;
	logic   res_deg_q;

	logic accept;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// Multiplier operand selection: the two halves of the cross term first, then the
	// coordinate sums against the finished cross term.
	always_comb begin
		unique case (state_q)
			S_X1: begin
				mul_a = OPA_W'(p_x_q);
				mul_b = OPB_W'(q_y_q);
			end
			S_X2: begin
				mul_a = OPA_W'(q_x_q);
				mul_b = OPB_W'(p_y_q);
			end
			S_WX: begin
				mul_a = OPA_W'(p_x_q) + OPA_W'(q_x_q);
				mul_b = c_q;
			end
			S_WY: begin
				mul_a = OPA_W'(p_y_q) + OPA_W'(q_y_q);
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Divisor is three times the doubled area; dividend is the x sum when the division is
	// set up and the y sum once the x quotient is finished.
	logic signed [AREA3_W-1:0] area3;
	logic [AREA3_W-1:0]        area3_mag;
	wsum_t                     wsel;
	logic [QUO_W-1:0]          wsel_mag;

	assign area3     = AREA3_W'(area_q) + (AREA3_W'(area_q) <<< 1);
	assign area3_mag = area3[AREA3_W-1] ? AREA3_W'(-area3) : AREA3_W'(area3);
	assign wsel      = (state_q == S_DFIN) ? wy_q : wx_q;
	assign wsel_mag  = wsel[WSUM_W-1] ? QUO_W'(-wsel) : QUO_W'(wsel);

	// One restoring division step: bring down the next dividend bit and subtract if it fits.
	logic [DIVR_W:0]   trial;
	logic              trial_ge;
	logic [DIVR_W:0]   trial_sub;
	logic [DIVR_W-1:0] rem_next;

	assign trial     = {rem_q, num_q[QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, dmag_q};
	assign trial_sub = trial - {1'b0, dmag_q};
	assign rem_next  = trial_ge ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];

	// Sign and saturate the finished quotient magnitude.
	logic               q_neg;
	logic [COORD_W-1:0] q_neg_val;
	coord_t             q_sat;

	assign q_neg     = nneg_q ^ dneg_q;
	assign q_neg_val = COORD_W'(0) - num_q[COORD_W-1:0];

	always_comb begin
		if (q_neg) begin
			if (num_q > QUO_W'(2 ** (COORD_W - 1))) begin
				q_sat = COORD_MIN;
			end else begin
				q_sat = coord_t'(q_neg_val);
			end
		end else begin
			if (num_q > QUO_W'(2 ** (COORD_W - 1) - 1)) begin
				q_sat = COORD_MAX;
			end else begin
				q_sat = coord_t'(num_q[COORD_W-1:0]);
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_q <= last_vertex;
					if (count_q >= CNT_MAX) begin
						// Ignored vertex: only a last mark matters, closing what was kept.
						p_x_q <= prev_x_q;
						p_y_q <= prev_y_q;
						q_x_q <= first_x_q;
						q_y_q <= first_y_q;
					end else if (count_q == '0) begin
						first_x_q <= vertex_x;
						first_y_q <= vertex_y;
						prev_x_q  <= vertex_x;
						prev_y_q  <= vertex_y;
						// A lone last vertex closes onto itself, which adds nothing.
						p_x_q <= vertex_x;
						p_y_q <= vertex_y;
						q_x_q <= vertex_x;
						q_y_q <= vertex_y;
					end else begin
						p_x_q    <= prev_x_q;
						p_y_q    <= prev_y_q;
						q_x_q    <= vertex_x;
						q_y_q    <= vertex_y;
						prev_x_q <= vertex_x;
						prev_y_q <= vertex_y;
					end
				end
			end
			S_X2: begin
				c_q <= OPB_W'(mul_q);
			end
			S_C: begin
				c_q <= c_q - OPB_W'(mul_q);
			end
			S_ACC: begin
				if (!closing_q && last_q) begin
					p_x_q <= prev_x_q;
					p_y_q <= prev_y_q;
					q_x_q <= first_x_q;
					q_y_q <= first_y_q;
				end
			end
			S_DSET: begin
				dmag_q <= area3_mag[DIVR_W-1:0];
				dneg_q <= area3[AREA3_W-1];
				num_q  <= wsel_mag;
				nneg_q <= wsel[WSUM_W-1];
				rem_q  <= '0;
				dcnt_q <= '0;
				if (area_q == '0) begin
					res_x_q   <= '0;
					res_y_q   <= '0;
					res_deg_q <= 1'b1;
				end else begin
					res_deg_q <= 1'b0;
				end
			end
			S_DIV: begin
				rem_q  <= rem_next;
				num_q  <= {num_q[QUO_W-2:0], trial_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_DFIN: begin
				if (!div_sel_q) begin
					res_x_q <= q_sat;
					num_q   <= wsel_mag;
					nneg_q  <= wsel[WSUM_W-1];
					rem_q   <= '0;
					dcnt_q  <= '0;
				end else begin
					res_y_q <= q_sat;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					centroid_x        <= res_x_q;
					centroid_y        <= res_y_q;
					degenerate        <= res_deg_q;
					too_many_vertices <= overflow_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control and accumulator registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			area_q     <= '0;
			wx_q       <= '0;
			wy_q       <= '0;
			closing_q  <= 1'b0;
			div_sel_q  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			// A result taken in the cycle that hands over the next one is replaced below.
			if (out_valid && out_ready && state_q != S_EMIT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (count_q >= CNT_MAX) begin
							overflow_q <= 1'b1;
							closing_q  <= last_vertex;
							if (last_vertex) begin
								state_q <= S_X1;
							end
						end else if (count_q == '0) begin
							count_q   <= count_q + 1'b1;
							closing_q <= last_vertex;
							if (last_vertex) begin
								state_q <= S_X1;
							end
						end else begin
							count_q   <= count_q + 1'b1;
							closing_q <= 1'b0;
							state_q   <= S_X1;
						end
					end
				end
				S_X1: state_q <= S_X2;
				S_X2: state_q <= S_C;
				S_C:  state_q <= S_WX;
				S_WX: begin
					area_q  <= area_q + AREA_W'(c_q);
					state_q <= S_WY;
				end
				S_WY: begin
					wx_q    <= wx_q + WSUM_W'(mul_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					wy_q <= wy_q + WSUM_W'(mul_q);
					if (closing_q) begin
						div_sel_q <= 1'b0;
						state_q   <= S_DSET;
					end else if (last_q) begin
						closing_q <= 1'b1;
						state_q   <= S_X1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DSET: begin
					if (area_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == DCNT_W'(QUO_W - 1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					if (!div_sel_q) begin
						div_sel_q <= 1'b1;
						state_q   <= S_DIV;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						count_q    <= '0;
						overflow_q <= 1'b0;
						area_q     <= '0;
						wx_q       <= '0;
						wy_q       <= '0;
						closing_q  <= 1'b0;
						div_sel_q  <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The restoring divider keeps its partial remainder below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dmag_q))
		else $error("divider remainder reached the divisor");

	// A degenerate result carries zero coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (centroid_x == '0 && centroid_y == '0))
		else $error("degenerate result with non-zero centroid");

	// The kept vertex count never passes the built maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("vertex count beyond maximum");

	// A vertex arriving at a full polygon marks the overflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && count_q >= CNT_MAX && !last_vertex) |=> overflow_q)
		else $error("ignored vertex did not raise overflow");

	// Division only starts on a polygon that holds at least one vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSET) |-> (count_q != '0))
		else $error("polygon closed with no vertices");

endmodule
